// ===== hdl/sbrp_pkg.sv =====
// Shared types and constants for the STUN binding response parser.
package sbrp_pkg;

    localparam int MAX_MESSAGE_BYTES = 512;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int ATTR_START_W      = 17;

    localparam logic [15:0] MSG_BINDING_RESPONSE = 16'h0101;
    localparam logic [31:0] MAGIC_COOKIE         = 32'h2112_A442;
    localparam logic [15:0] ATTR_XOR_MAPPED      = 16'h0020;
    localparam logic [15:0] ATTR_MAPPED          = 16'h0001;
    localparam logic [7:0]  FAMILY_IPV4          = 8'h01;
    localparam logic [POS_W-1:0] HEADER_BYTES    = POS_W'(20);

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_SHORT      = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_NO_ATTR    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [31:0] address;
        logic        from_xor_attribute;
    } t_out_word;

endpackage

// ===== hdl/stun_binding_response_parser.sv =====
// STUN binding response parser: takes one message byte per word, checks the
// header and walks the attributes for a mapped IPv4 address. A new byte word
// is accepted every cycle unless the input stalls; each byte passes through an
// input register and the header and attribute logic, and the result of a
// message's last byte is written to the result register. Input stalls only
// when a finished result is still waiting in the result register and the
// byte held in the input register ends another message.
module stun_binding_response_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sbrp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sbrp_pkg::t_out_word o_out_data
);

    logic                r_in_valid;
    sbrp_pkg::t_in_word  r_in;
    logic                r_out_valid;
    sbrp_pkg::t_out_word r_out;

    logic                w_out_free;
    logic                w_step;
    sbrp_pkg::t_out_word w_result;

    assign w_out_free = !r_out_valid || i_out_ready;
    // A byte that ends a message needs room in the result register.
    assign w_step     = r_in_valid && (!r_in.last_byte || w_out_free);
    assign o_in_ready = !r_in_valid || w_step;

    sbrp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_step && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.last_byte) |=> o_out_valid)
        else $error("last byte processed without a result word");

    a_blocked_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.last_byte && !w_out_free) |=> r_in_valid)
        else $error("last byte dropped while the result register was full");

    a_address_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != sbrp_pkg::ST_FOUND)
        |-> (o_out_data.address == 32'd0 && !o_out_data.from_xor_attribute))
        else $error("address reported on a failed parse");
`endif

endmodule

// ===== hdl/sbrp_core.sv =====
// Per-byte header check and attribute walk state for the STUN parser.
module sbrp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sbrp_pkg::t_in_word i_word,
    output sbrp_pkg::t_out_word o_result
);

    localparam int PW = sbrp_pkg::POS_W;
    localparam int AW = sbrp_pkg::ATTR_START_W;

    logic [PW-1:0] r_pos,        n_pos;
    logic [31:0]   r_hdr,        n_hdr;
    logic [15:0]   r_type,       n_type;
    logic [AW-1:0] r_attr_start, n_attr_start;
    logic [15:0]   r_atype,      n_atype;
    logic [15:0]   r_alen,       n_alen;
    logic [7:0]    r_family,     n_family;
    logic [31:0]   r_cand,       n_cand;
    logic          r_pending,    n_pending;
    logic [31:0]   r_found_addr, n_found_addr;
    logic          r_found,      n_found;
    logic          r_found_xor,  n_found_xor;
    logic          r_stopped,    n_stopped;

    logic [7:0]    w_d;
    logic          w_take;
    logic          w_in_walk;
    logic [AW-1:0] w_rel;
    logic [AW-1:0] w_vrel;

    // Offset of the attribute that follows one of the given length.
    function automatic logic [AW-1:0] next_start(input logic [AW-1:0] start,
                                                 input logic [15:0] len);
        logic [AW-1:0] padded;
        padded = (AW'(len) + AW'(3)) & ~AW'(3);
        return start + AW'(4) + padded;
    endfunction

    assign w_d       = i_word.data_byte;
    assign w_take    = i_step && (r_pos < PW'(sbrp_pkg::MAX_MESSAGE_BYTES));
    assign w_in_walk = (r_pos >= sbrp_pkg::HEADER_BYTES) && !r_stopped
                       && (AW'(r_pos) >= r_attr_start);
    assign w_rel     = AW'(r_pos) - r_attr_start;
    assign w_vrel    = w_rel - AW'(4);

    always_comb begin
        n_pos        = r_pos;
        n_hdr        = r_hdr;
        n_type       = r_type;
        n_attr_start = r_attr_start;
        n_atype      = r_atype;
        n_alen       = r_alen;
        n_family     = r_family;
        n_cand       = r_cand;
        n_pending    = r_pending;
        n_found_addr = r_found_addr;
        n_found      = r_found;
        n_found_xor  = r_found_xor;
        n_stopped    = r_stopped;
        o_result     = '{status: sbrp_pkg::ST_NO_ATTR, address: 32'd0,
                         from_xor_attribute: 1'b0};

        if (w_take) begin
            n_pos = r_pos + PW'(1);
            if (r_pos < PW'(2)) begin
                n_type = {r_type[7:0], w_d};
            end else if (r_pos >= PW'(4) && r_pos < PW'(8)) begin
                n_hdr = {r_hdr[23:0], w_d};
            end

            if (w_in_walk) begin
                if (w_rel < AW'(4)) begin
                    if (w_rel < AW'(2)) begin
                        n_atype = {r_atype[7:0], w_d};
                    end else begin
                        n_alen = {r_alen[7:0], w_d};
                    end
                    // The header is complete on its fourth byte.
                    if (w_rel == AW'(3)) begin
                        if ((r_atype == sbrp_pkg::ATTR_XOR_MAPPED
                             || r_atype == sbrp_pkg::ATTR_MAPPED)
                            && n_alen >= 16'd8) begin
                            n_pending = 1'b1;
                            n_family  = 8'd0;
                            n_cand    = 32'd0;
                        end else begin
                            n_pending    = 1'b0;
                            n_attr_start = next_start(r_attr_start, n_alen);
                        end
                    end
                end else if (!r_pending) begin
                    n_attr_start = next_start(r_attr_start, r_alen);
                end else begin
                    if (w_vrel == AW'(1)) begin
                        n_family = w_d;
                    end else if (w_vrel >= AW'(4) && w_vrel < AW'(8)) begin
                        n_cand = {r_cand[23:0], w_d};
                    end
                    if (w_vrel + AW'(1) == AW'(r_alen)) begin
                        if (n_family == sbrp_pkg::FAMILY_IPV4) begin
                            n_found_xor  = (r_atype == sbrp_pkg::ATTR_XOR_MAPPED);
                            n_found_addr = n_found_xor
                                           ? (n_cand ^ sbrp_pkg::MAGIC_COOKIE)
                                           : n_cand;
                            n_found      = 1'b1;
                            n_stopped    = 1'b1;
                            n_pending    = 1'b0;
                        end else begin
                            n_pending    = 1'b0;
                            n_attr_start = next_start(r_attr_start, r_alen);
                        end
                    end
                end
            end
        end

        if (i_step && i_word.last_byte) begin
            if (n_pos < sbrp_pkg::HEADER_BYTES) begin
                o_result.status = sbrp_pkg::ST_SHORT;
            end else if (n_type != sbrp_pkg::MSG_BINDING_RESPONSE
                         || n_hdr != sbrp_pkg::MAGIC_COOKIE) begin
                o_result.status = sbrp_pkg::ST_BAD_HEADER;
            end else if (n_found) begin
                o_result.status             = sbrp_pkg::ST_FOUND;
                o_result.address            = n_found_addr;
                o_result.from_xor_attribute = n_found_xor;
            end else begin
                o_result.status = sbrp_pkg::ST_NO_ATTR;
            end

            // The message is done; start clean for the next one.
            n_pos        = '0;
            n_hdr        = '0;
            n_type       = '0;
            n_attr_start = AW'(sbrp_pkg::HEADER_BYTES);
            n_atype      = '0;
            n_alen       = '0;
            n_family     = '0;
            n_cand       = '0;
            n_pending    = 1'b0;
            n_found_addr = '0;
            n_found      = 1'b0;
            n_found_xor  = 1'b0;
            n_stopped    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_hdr        <= '0;
            r_type       <= '0;
            r_attr_start <= AW'(sbrp_pkg::HEADER_BYTES);
            r_atype      <= '0;
            r_alen       <= '0;
            r_family     <= '0;
            r_cand       <= '0;
            r_pending    <= 1'b0;
            r_found_addr <= '0;
            r_found      <= 1'b0;
            r_found_xor  <= 1'b0;
            r_stopped    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_hdr        <= n_hdr;
            r_type       <= n_type;
            r_attr_start <= n_attr_start;
            r_atype      <= n_atype;
            r_alen       <= n_alen;
            r_family     <= n_family;
            r_cand       <= n_cand;
            r_pending    <= n_pending;
            r_found_addr <= n_found_addr;
            r_found      <= n_found;
            r_found_xor  <= n_found_xor;
            r_stopped    <= n_stopped;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.last_byte) |=> (r_pos == '0 && !r_found && !r_stopped))
        else $error("parser state not cleared after the last byte");

    a_stopped_has_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_found && !r_pending))
        else $error("walk stopped without a committed address");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(sbrp_pkg::MAX_MESSAGE_BYTES))
        else $error("byte position ran past the message limit");
`endif

endmodule
